// ===== rtl/swt_pkg.sv =====
// ----------------------------------------------------------------------------
// swt_pkg
// Shared types and constants for the system-information window tracker.
// ----------------------------------------------------------------------------
package swt_pkg;

   localparam int MAX_MESSAGES = 32;
   localparam int MSG_W        = 5;
   localparam int SLOT_W       = 18;
   localparam int QUO_W        = 13;

   // register indexes on the csr port
   localparam logic [2:0] CSR_WINDOW_LEN  = 3'd0;
   localparam logic [2:0] CSR_MSG_COUNT   = 3'd1;
   localparam logic [2:0] CSR_NUMEROLOGY  = 3'd2;
   localparam logic [2:0] CSR_PERIOD_LOW  = 3'd3;
   localparam logic [2:0] CSR_PERIOD_HIGH = 3'd4;

   // reciprocal of ten in 16 fractional bits
   localparam logic [12:0] RECIP_TEN = 13'd6554;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // configuration derived once and fanned out to every cell
   typedef struct packed {
      logic [SLOT_W-1:0] wrap;
      logic [SLOT_W-2:0] half;
      logic [10:0]       w;
      logic [7:0]        wq;
      logic [7:0]        wr;
      logic [7:0]        nslots;
      logic [5:0]        count;
   } cfg_type;

   // tick data walking down the chain
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] now;
      logic [9:0]        sfn;
      logic [7:0]        slot;
      logic [7:0]        rem;
      logic [QUO_W-1:0]  quo;
   } token_type;

   typedef struct packed {
      logic             valid;
      logic [MSG_W-1:0] msg;
   } grant_type;

endpackage

// ===== rtl/swt_cell.sv =====
// ----------------------------------------------------------------------------
// swt_cell
// One message slot: window state, timeout check and start match.
// ----------------------------------------------------------------------------
module swt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [4:0]              cell_id,
   input  logic [2:0]              period_code,
   input  swt_pkg::cfg_type        cfg,
   input  swt_pkg::grant_type      grant,
   input  logic                    clear_missed,
   input  swt_pkg::token_type      tok_in,
   output swt_pkg::token_type      tok_out,
   output logic                    open_out,
   output logic                    missed_out
);
   import swt_pkg::*;

   logic              open_ff, open_in;
   logic              sent_ff, sent_in;
   logic              missed_ff, missed_in;
   logic [SLOT_W-1:0] start_ff, start_in;
   token_type         tok_ff, tok_in_nxt;

   logic              active;
   logic [SLOT_W:0]   stop_sum;
   logic [SLOT_W-1:0] stop;
   logic [SLOT_W:0]   diff;
   logic              timeout;
   logic [9:0]        sfn_mask;
   logic              start_hit;
   logic [8:0]        rem_sum;

   assign active = {1'b0, cell_id} < cfg.count;

   // wrapped end of window and distance from it
   always_comb begin
      stop_sum = {1'b0, start_ff} + {{(SLOT_W-10){1'b0}}, cfg.w};
      if (stop_sum >= {1'b0, cfg.wrap}) begin
         stop = SLOT_W'(stop_sum - {1'b0, cfg.wrap});
      end else begin
         stop = stop_sum[SLOT_W-1:0];
      end
      if (tok_in.now >= stop) begin
         diff = {1'b0, tok_in.now} - {1'b0, stop};
      end else begin
         diff = {1'b0, tok_in.now} + {1'b0, cfg.wrap} - {1'b0, stop};
      end
      timeout = (diff != '0) && (diff < {2'b00, cfg.half});
   end

   // window start match
   always_comb begin
      sfn_mask  = ~(10'h3FF << ({1'b0, period_code} + 4'd3));
      start_hit = (tok_in.slot == tok_in.rem) &&
                  ({{(QUO_W-10){1'b0}}, (tok_in.sfn & sfn_mask)} == tok_in.quo);
   end

   // state update
   always_comb begin
      open_in   = open_ff;
      sent_in   = sent_ff;
      missed_in = clear_missed ? 1'b0 : missed_ff;
      start_in  = start_ff;
      if (tok_in.valid) begin
         if (!active) begin
            open_in = 1'b0;
            sent_in = 1'b0;
         end else if (open_ff) begin
            if (timeout) begin
               missed_in = !sent_ff;
               open_in   = 1'b0;
               sent_in   = 1'b0;
            end
         end else if (start_hit) begin
            open_in  = 1'b1;
            start_in = tok_in.now;
         end
      end
      if (grant.valid && grant.msg == cell_id && active && open_ff) begin
         open_in = 1'b0;
         sent_in = 1'b1;
      end
   end

   // offset of the next message: x grows by w
   always_comb begin
      tok_in_nxt = tok_in;
      rem_sum    = {1'b0, tok_in.rem} + {1'b0, cfg.wr};
      if (rem_sum >= {1'b0, cfg.nslots}) begin
         tok_in_nxt.rem = 8'(rem_sum - {1'b0, cfg.nslots});
         tok_in_nxt.quo = tok_in.quo + {{(QUO_W-8){1'b0}}, cfg.wq} + QUO_W'(1);
      end else begin
         tok_in_nxt.rem = rem_sum[7:0];
         tok_in_nxt.quo = tok_in.quo + {{(QUO_W-8){1'b0}}, cfg.wq};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         sent_ff      <= 1'b0;
         missed_ff    <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         open_ff      <= open_in;
         sent_ff      <= sent_in;
         missed_ff    <= missed_in;
         tok_ff.valid <= tok_in_nxt.valid;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      tok_ff.now  <= tok_in_nxt.now;
      tok_ff.sfn  <= tok_in_nxt.sfn;
      tok_ff.slot <= tok_in_nxt.slot;
      tok_ff.rem  <= tok_in_nxt.rem;
      tok_ff.quo  <= tok_in_nxt.quo;
   end

   assign tok_out    = tok_ff;
   assign open_out   = open_ff;
   assign missed_out = missed_ff;

endmodule

// ===== rtl/si_window_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// si_window_tracker_unit
// A slot tick walks a chain of 32 message cells, one cell per cycle.
// Response: loaded from the cell flags once a tick has passed the last cell, or after a grant.
// Requests: one at a time; req_stall stays high from accept until the response is loaded,
// which waits while a previous response is held by rsp_stall.
// Reset: synchronous, clears windows, flags, valids, state and CSRs; data registers are not reset.
// ----------------------------------------------------------------------------
module si_window_tracker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [0:0]  req_type,
   input  logic [9:0]  req_frame_number,
   input  logic [7:0]  req_slot_in_frame,
   input  logic [4:0]  req_message_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_open_mask,
   output logic [31:0] rsp_missed_mask,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_write_data
);
   import swt_pkg::*;

   // configuration registers
   logic [10:0] w_ff;
   logic [5:0]  count_ff;
   logic [2:0]  mu_ff;
   logic [47:0] codes_lo_ff;
   logic [47:0] codes_hi_ff;
   cfg_type     cfg_ff, cfg_in;
   cfg_type     cfg_cell;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff        <= 11'd20;
         count_ff    <= 6'd0;
         mu_ff       <= 3'd0;
         codes_lo_ff <= 48'd0;
         codes_hi_ff <= 48'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WINDOW_LEN:  w_ff        <= csr_write_data[10:0];
            CSR_MSG_COUNT:   count_ff    <= csr_write_data[5:0];
            CSR_NUMEROLOGY:  mu_ff       <= csr_write_data[2:0];
            CSR_PERIOD_LOW:  codes_lo_ff <= csr_write_data;
            CSR_PERIOD_HIGH: codes_hi_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // derived configuration: slots per frame, wrap, w split into N parts
   logic [2:0]  mu_c;
   logic [10:0] w_sh;
   logic [23:0] recip_prod;
   logic [7:0]  wq;
   logic [15:0] wq_n;

   always_comb begin
      mu_c          = (mu_ff > 3'd4) ? 3'd4 : mu_ff;
      w_sh          = w_ff >> mu_c;
      recip_prod    = {13'd0, w_sh} * {11'd0, RECIP_TEN};
      wq            = recip_prod[23:16];
      cfg_in.nslots = 8'd10 << mu_c;
      wq_n          = {8'd0, wq} * {8'd0, cfg_in.nslots};
      cfg_in.wq     = wq;
      cfg_in.wr     = 8'(w_ff - wq_n[10:0]);
      cfg_in.wrap   = SLOT_W'(18'd10240 << mu_c);
      cfg_in.half   = cfg_in.wrap[SLOT_W-1:1];
      cfg_in.w      = w_ff;
      cfg_in.count  = (count_ff > 6'd32) ? 6'd32 : count_ff;
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   // message count seen by a grant in the cycle right after a write
   always_comb begin
      cfg_cell       = cfg_ff;
      cfg_cell.count = cfg_in.count;
   end

   // control
   state_type   state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        accept;
   logic        load_rsp;
   logic        rsp_valid_ff;
   logic [31:0] open_ff, missed_ff;
   logic [31:0] open_vec, missed_vec;

   assign accept   = req_valid && !req_stall;
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in   = 5'd0;
               state_in = req_type[0] ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(MAX_MESSAGES - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the controller
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         open_ff   <= open_vec;
         missed_ff <= missed_vec;
      end
   end

   // tick entering the chain
   token_type   tok0_ff;
   logic [13:0] sfn_x10;
   logic [SLOT_W:0] now_raw;
   logic [SLOT_W-1:0] now_c;

   always_comb begin
      sfn_x10 = {1'b0, req_frame_number, 3'd0} + {3'd0, req_frame_number, 1'b0};
      now_raw = ({5'd0, sfn_x10} << mu_c) + {11'd0, req_slot_in_frame};
      if (now_raw >= {1'b0, cfg_in.wrap}) begin
         now_c = SLOT_W'(now_raw - {1'b0, cfg_in.wrap});
      end else begin
         now_c = now_raw[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok0_ff.valid <= 1'b0;
      end else begin
         tok0_ff.valid <= accept && !req_type[0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tok0_ff.now  <= now_c;
         tok0_ff.sfn  <= req_frame_number;
         tok0_ff.slot <= req_slot_in_frame;
         tok0_ff.rem  <= 8'd0;
         tok0_ff.quo  <= '0;
      end
   end

   grant_type grant;
   assign grant.valid = accept && req_type[0];
   assign grant.msg   = req_message_index;

   // chain of message cells
   token_type tok_chain [MAX_MESSAGES+1];
   assign tok_chain[0] = tok0_ff;

   for (genvar g = 0; g < MAX_MESSAGES; g++) begin : g_cell
      logic [2:0] code;
      if (g < 16) begin : g_lo
         assign code = codes_lo_ff[3*g +: 3];
      end else begin : g_hi
         assign code = codes_hi_ff[3*(g-16) +: 3];
      end
      swt_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_id      (5'(g)),
         .period_code  (code),
         .cfg          (cfg_cell),
         .grant        (grant),
         .clear_missed (accept),
         .tok_in       (tok_chain[g]),
         .tok_out      (tok_chain[g+1]),
         .open_out     (open_vec[g]),
         .missed_out   (missed_vec[g])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_open_mask   = open_ff;
   assign rsp_missed_mask = missed_ff;

endmodule
